// ===== design/slider_text_reveal_top_assert.svh =====
// assertion macros for the slider text reveal block
// used by slider_text_reveal_top, expects i_clk and i_rst_n in scope
`ifndef SLIDER_TEXT_REVEAL_TOP_ASSERT_SVH
`define SLIDER_TEXT_REVEAL_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define STR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define STR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/str_pkg.sv =====
// shared types and constants for the slider text reveal block
// no dependencies
`default_nettype none

package str_pkg;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_START = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_DWELL = 2'd0,
        CFG_SPIN  = 2'd1,
        CFG_COUNT = 2'd2,
        CFG_SEED  = 2'd3
    } t_cfg_reg;

    localparam logic [7:0]  SPACE_CODE  = 8'h20;
    localparam logic [7:0]  CHAR_BASE   = 8'h30;
    localparam logic [6:0]  CHAR_SPAN   = 7'd43;
    // floor(2^37 / 43): quotient estimate is exact or one low
    localparam logic [31:0] RECIP_M     = 32'd3196254731;
    localparam int          RECIP_SHIFT = 37;
    localparam int          XS_A        = 13;
    localparam int          XS_B        = 17;
    localparam int          XS_C        = 5;

    // writes caused by one accepted transaction, in order: blanks, reveal, random
    typedef struct packed {
        logic [3:0] blank_cnt;
        logic       has_rev;
        logic [2:0] rev_cell;
        logic [7:0] rev_char;
        logic       rev_dot;
        logic       has_rand;
        logic [2:0] rand_cell;
        logic [6:0] rand_x7;   // low bits of generator word
        logic [6:0] rand_q7;   // low bits of quotient estimate
        logic       done;
    } t_job;

endpackage

`default_nettype wire

// ===== design/str_ctrl.sv =====
// reveal state, text store, configuration registers and write planning
// depends on str_pkg
`default_nettype none

module str_ctrl #(
    parameter int CELLS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_accept,
    input  wire logic [1:0]  i_action,
    input  wire logic [2:0]  i_cell_index,
    input  wire logic [7:0]  i_text_char,
    input  wire logic        i_text_dot,
    output      logic        o_job_load,
    output      str_pkg::t_job o_job
);
    import str_pkg::*;

    localparam int CIW = (CELLS > 1) ? $clog2(CELLS) : 1;

    function automatic logic [31:0] xorshift(input logic [31:0] v);
        logic [31:0] x;
        x = v;
        x = x ^ (x << XS_A);
        x = x ^ (x >> XS_B);
        x = x ^ (x << XS_C);
        return x;
    endfunction

    logic [15:0]    r_dwell_ticks;
    logic [15:0]    r_spin_ticks;
    logic [3:0]     r_cell_count;
    logic [31:0]    r_rng_seed;

    logic [7:0]     r_text [CELLS];
    logic           r_dot  [CELLS];
    logic [CIW-1:0] r_cursor;
    logic [15:0]    r_dwell;
    logic [15:0]    r_spin;
    logic           r_finished;
    logic [31:0]    r_rng;

    logic [7:0]     n_text [CELLS];
    logic           n_dot  [CELLS];
    logic [CIW-1:0] n_cursor;
    logic [15:0]    n_dwell;
    logic [15:0]    n_spin;
    logic           n_finished;
    logic [31:0]    n_rng;

    logic [3:0]     w_live;
    logic [15:0]    w_dwell_inc;
    logic [15:0]    w_spin_inc;
    logic [4:0]     w_next_pos;
    logic [31:0]    w_seed_odd;
    logic [31:0]    w_rand_word;
    logic [63:0]    w_prod;
    t_job           w_job;
    logic           w_job_load;

    assign w_live      = ({1'b0, r_cell_count} < 5'(CELLS)) ? r_cell_count : 4'(CELLS);
    assign w_dwell_inc = (r_dwell == 16'hFFFF) ? r_dwell : r_dwell + 16'd1;
    assign w_spin_inc  = (r_spin == 16'hFFFF) ? r_spin : r_spin + 16'd1;
    assign w_next_pos  = 5'(r_cursor) + 5'd1;
    assign w_seed_odd  = r_rng_seed | 32'd1;
    assign w_rand_word = xorshift((t_action'(i_action) == ACT_START) ? w_seed_odd : r_rng);
    assign w_prod      = w_rand_word * RECIP_M;

    always_comb begin
        n_text     = r_text;
        n_dot      = r_dot;
        n_cursor   = r_cursor;
        n_dwell    = r_dwell;
        n_spin     = r_spin;
        n_finished = r_finished;
        n_rng      = r_rng;
        w_job      = '0;
        w_job.rand_x7 = w_rand_word[6:0];
        w_job.rand_q7 = w_prod[RECIP_SHIFT +: 7];
        w_job_load = 1'b0;
        if (i_accept) begin
            case (t_action'(i_action))
                ACT_TICK: begin
                    if (!r_finished) begin
                        n_dwell = w_dwell_inc;
                        n_spin  = w_spin_inc;
                        if (w_dwell_inc >= r_dwell_ticks) begin
                            // reveal at the cursor, then move on
                            w_job.has_rev  = 1'b1;
                            w_job.rev_cell = 3'(r_cursor);
                            w_job.rev_char = r_text[r_cursor];
                            w_job.rev_dot  = r_dot[r_cursor];
                            n_cursor       = CIW'(w_next_pos);
                            n_dwell        = '0;
                            n_spin         = '0;
                            if (w_next_pos >= {1'b0, w_live}) begin
                                n_finished = 1'b1;
                            end else begin
                                w_job.has_rand  = 1'b1;
                                w_job.rand_cell = w_next_pos[2:0];
                                n_rng           = w_rand_word;
                            end
                        end else if (w_spin_inc >= r_spin_ticks) begin
                            w_job.has_rand  = 1'b1;
                            w_job.rand_cell = 3'(r_cursor);
                            n_rng           = w_rand_word;
                            n_spin          = '0;
                        end
                        w_job_load = w_job.has_rev | w_job.has_rand;
                    end
                end
                ACT_LOAD: begin
                    for (int j = 0; j < CELLS; j++) begin
                        if (4'(j) == {1'b0, i_cell_index}) begin
                            n_text[j] = i_text_char;
                            n_dot[j]  = i_text_dot;
                        end
                    end
                end
                ACT_START: begin
                    w_job.blank_cnt = w_live;
                    n_cursor        = '0;
                    n_dwell         = '0;
                    n_spin          = '0;
                    if (w_live != 4'd0) begin
                        w_job.has_rand  = 1'b1;
                        w_job.rand_cell = 3'd0;
                        n_rng           = w_rand_word;
                        n_finished      = 1'b0;
                        w_job_load      = 1'b1;
                    end else begin
                        n_rng      = w_seed_odd;
                        n_finished = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        w_job.done = n_finished;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell_ticks <= 16'd500;
            r_spin_ticks  <= 16'd50;
            r_cell_count  <= 4'd8;
            r_rng_seed    <= 32'd1;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_DWELL: r_dwell_ticks <= i_cfg_data[15:0];
                CFG_SPIN:  r_spin_ticks  <= i_cfg_data[15:0];
                CFG_COUNT: r_cell_count  <= i_cfg_data[3:0];
                CFG_SEED:  r_rng_seed    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < CELLS; j++) begin
                r_text[j] <= SPACE_CODE;
                r_dot[j]  <= 1'b0;
            end
            r_cursor   <= '0;
            r_dwell    <= '0;
            r_spin     <= '0;
            r_finished <= 1'b1;
            r_rng      <= 32'd1;
        end else begin
            r_text     <= n_text;
            r_dot      <= n_dot;
            r_cursor   <= n_cursor;
            r_dwell    <= n_dwell;
            r_spin     <= n_spin;
            r_finished <= n_finished;
            r_rng      <= n_rng;
        end
    end

    assign o_job_load = w_job_load;
    assign o_job      = w_job;

endmodule

`default_nettype wire

// ===== design/str_emit.sv =====
// write sequencer: walks one planned job and feeds the output register
// depends on str_pkg
`default_nettype none

module str_emit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_load,
    input  wire str_pkg::t_job i_job,
    output      logic          o_job_ready,
    output      logic          o_m_valid,
    input  wire logic          i_m_ready,
    output      logic [2:0]    o_cell,
    output      logic [7:0]    o_char,
    output      logic          o_dot,
    output      logic          o_last,
    output      logic          o_done
);
    import str_pkg::*;

    logic       r_jv;
    t_job       r_job;
    logic [3:0] r_blank_left;
    logic [3:0] r_blank_idx;
    logic       r_rev_pend;
    logic       r_rand_pend;

    logic       r_m_valid;
    logic [2:0] r_cell;
    logic [7:0] r_char;
    logic       r_dot;
    logic       r_last;
    logic       r_done;

    logic       w_fire;
    logic       w_is_last;
    logic [6:0] w_qm;
    logic [6:0] w_r0;
    logic [6:0] w_rem;
    logic [2:0] w_cell;
    logic [7:0] w_char;
    logic       w_dot;

    // remainder from the quotient estimate: true value below 86, so 7 bits suffice
    assign w_qm  = 7'(r_job.rand_q7 * CHAR_SPAN);
    assign w_r0  = r_job.rand_x7 - w_qm;
    assign w_rem = (w_r0 >= CHAR_SPAN) ? w_r0 - CHAR_SPAN : w_r0;

    always_comb begin
        if (r_blank_left != 4'd0) begin
            w_cell    = r_blank_idx[2:0];
            w_char    = SPACE_CODE;
            w_dot     = 1'b0;
            w_is_last = (r_blank_left == 4'd1) && !r_rev_pend && !r_rand_pend;
        end else if (r_rev_pend) begin
            w_cell    = r_job.rev_cell;
            w_char    = r_job.rev_char;
            w_dot     = r_job.rev_dot;
            w_is_last = !r_rand_pend;
        end else begin
            w_cell    = r_job.rand_cell;
            w_char    = CHAR_BASE + {1'b0, w_rem};
            w_dot     = 1'b0;
            w_is_last = 1'b1;
        end
    end

    assign w_fire      = r_jv && (!r_m_valid || i_m_ready);
    assign o_job_ready = !r_jv || (w_fire && w_is_last);

    // a new job only loads once the current one is empty or sends its last write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jv <= 1'b0;
        end else begin
            if (i_job_load) begin
                r_jv         <= 1'b1;
                r_job        <= i_job;
                r_blank_left <= i_job.blank_cnt;
                r_blank_idx  <= 4'd0;
                r_rev_pend   <= i_job.has_rev;
                r_rand_pend  <= i_job.has_rand;
            end else if (w_fire) begin
                if (r_blank_left != 4'd0) begin
                    r_blank_left <= r_blank_left - 4'd1;
                    r_blank_idx  <= r_blank_idx + 4'd1;
                end else if (r_rev_pend) begin
                    r_rev_pend <= 1'b0;
                end else begin
                    r_rand_pend <= 1'b0;
                end
                if (w_is_last) begin
                    r_jv <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_fire) begin
            r_m_valid <= 1'b1;
            r_cell    <= w_cell;
            r_char    <= w_char;
            r_dot     <= w_dot;
            r_last    <= w_is_last;
            r_done    <= r_job.done;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_cell    = r_cell;
    assign o_char    = r_char;
    assign o_dot     = r_dot;
    assign o_last    = r_last;
    assign o_done    = r_done;

endmodule

`default_nettype wire

// ===== design/slider_text_reveal_top.sv =====
// slider text reveal: top level with stream ports and configuration write port
// depends on str_pkg, str_ctrl, str_emit and slider_text_reveal_top_assert.svh
`default_nettype none

// Drives a row of character display cells with a sliding reveal. Each input
// transaction carries an action in tuser: a one millisecond tick, a text cell
// load or a start. Every transaction is planned combinationally against the
// reveal state (cursor, saturating dwell and spin counters, xorshift32 word,
// text store); the writes it causes are handed to a sequencer that puts them
// out one per cycle through an output register while the output is not
// stalled. Loads and ticks with at most one write can arrive back to back
// while the output is not stalled. A tick that reveals and moves on to
// another cell gives two writes; a start gives a blank for each cell in use,
// then a random character at cell 0, or no write when no cell is in use. A
// transaction holds the input until its last write is sent. A write passes
// the sequencer job register, then the output register. Configuration is to
// be written while idle, not enforced by the block; it is always accepted.

`include "slider_text_reveal_top_assert.svh"

module slider_text_reveal_top #(
    parameter int CELLS = 8   // display cells, 1 to 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // configuration writes: 0 dwell, 1 spin, 2 cell count, 3 seed
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,

    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // cell_index[2:0], text_char[10:3], text_dot[11]
    input  wire logic [1:0]  s_axis_tuser,   // action[1:0]

    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [15:0] m_axis_tdata,   // write_cell[2:0], write_char[10:3],
                                             // write_dot[11], anim_done[12]
    output      logic        m_axis_tlast    // last write of the transaction
);
    import str_pkg::*;

    logic       w_accept;
    logic       w_job_load;
    t_job       w_job;
    logic       w_job_ready;
    logic [2:0] w_cell;
    logic [7:0] w_char;
    logic       w_dot;
    logic       w_done;

    // registers should only change while idle, not enforced here; the port never stalls
    assign o_cfg_ready = 1'b1;

    // input is taken whenever the sequencer frees up by the next edge
    assign s_axis_tready = w_job_ready;
    assign w_accept      = s_axis_tvalid & s_axis_tready;

    // planning stage: state update and list of writes
    str_ctrl #(
        .CELLS (CELLS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (w_accept),
        .i_action     (s_axis_tuser),
        .i_cell_index (s_axis_tdata[2:0]),
        .i_text_char  (s_axis_tdata[10:3]),
        .i_text_dot   (s_axis_tdata[11]),
        .o_job_load   (w_job_load),
        .o_job        (w_job)
    );

    // write sequencer and output register, random character folding lives here
    str_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_load  (w_job_load),
        .i_job       (w_job),
        .o_job_ready (w_job_ready),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_cell      (w_cell),
        .o_char      (w_char),
        .o_dot       (w_dot),
        .o_last      (m_axis_tlast),
        .o_done      (w_done)
    );

    assign m_axis_tdata = {3'b000, w_done, w_dot, w_char, w_cell};

    // a write list only appears for an accepted transaction
    `STR_ASSERT_IMPL(a_job_on_accept, w_job_load, w_accept,
        "write list planned without an accepted transaction")

    // a text load never causes writes
    `STR_ASSERT_IMPL(a_load_silent, w_accept && (s_axis_tuser == ACT_LOAD), !w_job_load,
        "text load produced writes")

    // once a single-write job loads, the input is open again unless the output still holds a write
    `STR_ASSERT_NEXT(a_ready_after_single,
        w_job_load && !w_job.has_rev && (w_job.blank_cnt == 4'd0),
        s_axis_tready || m_axis_tvalid,
        "input stalled with nothing pending")

endmodule

`default_nettype wire

// ===== tb/slider_text_reveal_top_tb.sv =====
// self-checking testbench for slider_text_reveal_top: directed table, random phases
// depends on str_pkg and the slider_text_reveal_top rtl
`default_nettype none

module slider_text_reveal_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import str_pkg::*;

    localparam int CELLS      = 8;
    localparam int RAND_ITEMS = 380;
    localparam int SETTLE     = 4;     // margin for a write still passing the job and output registers
    localparam int TAIL       = 16;
    localparam int WDOG_LIMIT = 500;   // cycles with no transaction on any channel

    // one cell write as seen on the master side
    typedef struct packed {
        logic [2:0] wcell;
        logic [7:0] chr;
        logic       dot;
        logic       last;
        logic       done;
    } t_wr;

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;

    // one row of the directed table: an input transaction or a register write
    typedef struct {
        t_row_kind  kind;
        t_action    act;
        logic [2:0] idx;
        logic [7:0] ch;
        logic       dot;
        bit         fixed;     // expected writes typed in below, not predicted
        int         n_fixed;   // 0 or 1
        t_wr        wr_fixed;
        t_cfg_reg   cfg_reg;
        logic [31:0] cfg_val;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // cell_index[2:0], text_char[10:3], text_dot[11]
    logic [1:0]  s_axis_tuser;    // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // write_cell[2:0], write_char[10:3], write_dot[11],
                                  // anim_done[12]
    logic        m_axis_tlast;

    slider_text_reveal_top #(
        .CELLS(CELLS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // reveal model: configuration and animation state kept by the bench
    // ---------------------------------------------------------------
    logic [15:0] dwell_lim;
    logic [15:0] spin_lim;
    logic [3:0]  count_reg;
    logic [31:0] seed_reg;
    logic [7:0]  text_mem [CELLS];
    logic        dot_mem  [CELLS];
    logic [3:0]  cur_cell;
    logic [15:0] dwell_cnt;
    logic [15:0] spin_cnt;
    bit          anim_over;
    logic [31:0] xs_word;

    t_wr fresh_writes[$];     // writes of the transaction being predicted
    t_wr pending_writes[$];   // writes still owed by the block, oldest first

    // bookkeeping shared between the driving processes and the monitor
    int  items_taken;
    int  outs_taken;
    int  cfg_taken;
    int  idle_cycles;
    int  errs;
    int  rand_items;
    bit  calm;                // no idling on either side while set

    // attributes of the input transaction on the bus right now
    bit  cur_fixed;
    int  cur_n_fixed;
    t_wr cur_wr_fixed;

    function automatic logic [15:0] sat_up(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // xorshift32 step, folded into the random character range
    function automatic logic [7:0] spin_char();
        logic [31:0] x;
        x = xs_word;
        x ^= x << XS_A;
        x ^= x >> XS_B;
        x ^= x << XS_C;
        xs_word = x;
        return CHAR_BASE + 8'(x % 32'(CHAR_SPAN));
    endfunction

    function automatic void add_write(input logic [2:0] wcell, input logic [7:0] chr,
                                      input logic dot);
        fresh_writes.push_back(t_wr'{wcell, chr, dot, 1'b0, 1'b0});
    endfunction

    // works out the cell writes one accepted transaction causes
    task automatic predict_writes(input t_action act, input logic [2:0] idx,
                                  input logic [7:0] ch, input logic dot);
        int         live;
        logic [2:0] c;
        live = (int'(count_reg) < CELLS) ? int'(count_reg) : CELLS;
        fresh_writes.delete();
        case (act)
            ACT_TICK: begin
                if (!anim_over) begin
                    dwell_cnt = sat_up(dwell_cnt);
                    spin_cnt  = sat_up(spin_cnt);
                    // dwell wins over spin when both are due
                    if (dwell_cnt >= dwell_lim) begin
                        c = cur_cell[2:0];
                        add_write(c, text_mem[c], dot_mem[c]);
                        cur_cell  = {1'b0, c} + 4'd1;
                        dwell_cnt = '0;
                        spin_cnt  = '0;
                        if (int'(c) + 1 >= live) begin
                            anim_over = 1'b1;
                        end else begin
                            add_write(cur_cell[2:0], spin_char(), 1'b0);
                        end
                    end else if (spin_cnt >= spin_lim) begin
                        add_write(cur_cell[2:0], spin_char(), 1'b0);
                        spin_cnt = '0;
                    end
                end
            end
            ACT_LOAD: begin
                if (int'(idx) < CELLS) begin
                    text_mem[idx] = ch;
                    dot_mem[idx]  = dot;
                end
            end
            ACT_START: begin
                for (int i = 0; i < live; i++) begin
                    add_write(3'(i), SPACE_CODE, 1'b0);
                end
                cur_cell  = '0;
                dwell_cnt = '0;
                spin_cnt  = '0;
                xs_word   = seed_reg | 32'd1;
                anim_over = (live == 0);
                if (!anim_over) begin
                    add_write(3'd0, spin_char(), 1'b0);
                end
            end
            default: begin
            end
        endcase
        foreach (fresh_writes[k]) begin
            fresh_writes[k].last = (k == fresh_writes.size() - 1);
            fresh_writes[k].done = anim_over;
        end
    endtask

    // ---------------------------------------------------------------
    // monitor: every transaction is seen here at the rising edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_wr got;
        t_wr want;
        bit  moved;
        if (i_rst_n) begin
            moved = 1'b0;
            // register write: update the bench copy of the configuration
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_DWELL: dwell_lim = i_cfg_data[15:0];
                    CFG_SPIN:  spin_lim  = i_cfg_data[15:0];
                    CFG_COUNT: count_reg = i_cfg_data[3:0];
                    CFG_SEED:  seed_reg  = i_cfg_data;
                    default: begin
                    end
                endcase
                cfg_taken++;
                moved = 1'b1;
            end
            // input transaction: predict first, so a write is never seen before its cause
            if (s_axis_tvalid && s_axis_tready) begin
                predict_writes(t_action'(s_axis_tuser), s_axis_tdata[2:0],
                               s_axis_tdata[10:3], s_axis_tdata[11]);
                if (cur_fixed) begin
                    fresh_writes.delete();
                    if (cur_n_fixed > 0) begin
                        fresh_writes.push_back(cur_wr_fixed);
                    end
                end
                foreach (fresh_writes[k]) begin
                    pending_writes.push_back(fresh_writes[k]);
                end
                items_taken++;
                moved = 1'b1;
            end
            // output transaction: compare against the oldest expected write
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_wr'{m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tdata[11],
                            m_axis_tlast, m_axis_tdata[12]};
                if (pending_writes.size() == 0) begin
                    $error("write with nothing expected: cell %0d char %h",
                           got.wcell, got.chr);
                    errs++;
                end else begin
                    want = pending_writes.pop_front();
                    if (got.wcell != want.wcell) begin
                        $error("write_cell: expected %0d, got %0d", want.wcell, got.wcell);
                        errs++;
                    end
                    if (got.chr != want.chr) begin
                        $error("write_char: expected %h, got %h", want.chr, got.chr);
                        errs++;
                    end
                    if (got.dot != want.dot) begin
                        $error("write_dot: expected %0d, got %0d", want.dot, got.dot);
                        errs++;
                    end
                    if (got.last != want.last) begin
                        $error("last_of_run: expected %0d, got %0d", want.last, got.last);
                        errs++;
                    end
                    if (got.done != want.done) begin
                        $error("anim_done: expected %0d, got %0d", want.done, got.done);
                        errs++;
                    end
                end
                outs_taken++;
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // watchdog: a stuck handshake ends the run
    always @(negedge i_clk) begin
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles, %0d writes owed",
                     idle_cycles, pending_writes.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // drivers: everything changes at the falling edge
    // ---------------------------------------------------------------

    // one input transaction after a random gap; returns once it is accepted
    task automatic send(input t_action act, input logic [2:0] idx, input logic [7:0] ch,
                        input logic dot, input bit fixed, input int n_fixed,
                        input t_wr wr_fixed);
        int gap;
        int seen;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'b0, dot, ch, idx};
        cur_fixed     = fixed;
        cur_n_fixed   = n_fixed;
        cur_wr_fixed  = wr_fixed;
        s_axis_tvalid <= 1'b1;
        seen = items_taken;
        do @(negedge i_clk); while (items_taken == seen);
    endtask

    // input transaction with every field random, checked against the model
    task automatic send_rand(input t_action act);
        send(act, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)), 1'b0, 0, '0);
        if (act != ACT_NONE) begin
            rand_items++;
        end
    endtask

    // register write once the block has nothing left to put out
    task automatic cfg_write(input t_cfg_reg idx, input logic [31:0] val);
        int seen;
        s_axis_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(negedge i_clk);
        // a transaction with no writes may still be in flight
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        seen = cfg_taken;
        do @(negedge i_clk); while (cfg_taken == seen);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_row row_item(input t_action act, input logic [2:0] idx,
                                      input logic [7:0] ch, input logic dot);
        t_row r;
        r = '{kind: ROW_ITEM, act: act, idx: idx, ch: ch, dot: dot, fixed: 1'b0,
              n_fixed: 0, wr_fixed: '0, cfg_reg: CFG_DWELL, cfg_val: '0};
        return r;
    endfunction

    // row whose writes are typed in: none, or one given write
    function automatic t_row row_fixed(input t_action act, input logic [2:0] idx,
                                       input logic [7:0] ch, input logic dot,
                                       input int n, input t_wr wr);
        t_row r;
        r = row_item(act, idx, ch, dot);
        r.fixed    = 1'b1;
        r.n_fixed  = n;
        r.wr_fixed = wr;
        return r;
    endfunction

    function automatic t_row row_cfg(input t_cfg_reg idx, input logic [31:0] val);
        t_row r;
        r = row_item(ACT_NONE, '0, '0, 1'b0);
        r.kind    = ROW_CFG;
        r.cfg_reg = idx;
        r.cfg_val = val;
        return r;
    endfunction

    // result side: stall for a random number of cycles before each write
    initial begin
        int gap;
        int seen;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            seen = outs_taken;
            do @(negedge i_clk); while (outs_taken == seen);
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        t_row dir_tab[$];
        int   body_len;
        int   r;
        bit   first_phase;

        // inputs known from time zero, model at its reset values
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        dwell_lim     = 16'd500;
        spin_lim      = 16'd50;
        count_reg     = 4'd8;
        seed_reg      = 32'd1;
        foreach (text_mem[i]) begin
            text_mem[i] = SPACE_CODE;
            dot_mem[i]  = 1'b0;
        end
        cur_cell      = '0;
        dwell_cnt     = '0;
        spin_cnt      = '0;
        anim_over     = 1'b1;
        xs_word       = 32'd1;
        items_taken   = 0;
        outs_taken    = 0;
        cfg_taken     = 0;
        idle_cycles   = 0;
        errs          = 0;
        rand_items    = 0;
        calm          = 1'b0;
        cur_fixed     = 1'b0;
        cur_n_fixed   = 0;
        cur_wr_fixed  = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table, starting from the reset configuration
        // idle after reset: tick, loads and the unused action write nothing
        dir_tab.push_back(row_fixed(ACT_TICK, 3'd0, 8'h00, 1'b0, 0, '0));
        dir_tab.push_back(row_fixed(ACT_LOAD, 3'd0, 8'hFF, 1'b1, 0, '0));
        dir_tab.push_back(row_fixed(ACT_LOAD, 3'd7, 8'h00, 1'b0, 0, '0));
        dir_tab.push_back(row_fixed(ACT_NONE, 3'd7, 8'hFF, 1'b1, 0, '0));
        // start with all eight cells, then a tick far from dwell and spin
        dir_tab.push_back(row_item(ACT_START, 3'd5, 8'hA5, 1'b1));
        dir_tab.push_back(row_item(ACT_TICK, 3'd2, 8'h5A, 1'b0));
        // no cells in use: start writes nothing and the animation is over
        dir_tab.push_back(row_cfg(CFG_COUNT, 32'd0));
        dir_tab.push_back(row_fixed(ACT_START, 3'd0, 8'h00, 1'b0, 0, '0));
        dir_tab.push_back(row_fixed(ACT_TICK, 3'd0, 8'h00, 1'b0, 0, '0));
        // one cell, zero dwell: the first tick reveals cell 0 and finishes
        dir_tab.push_back(row_cfg(CFG_COUNT, 32'd1));
        dir_tab.push_back(row_cfg(CFG_DWELL, 32'd0));
        dir_tab.push_back(row_cfg(CFG_SPIN, 32'd0));
        dir_tab.push_back(row_item(ACT_START, 3'd0, 8'h00, 1'b0));
        dir_tab.push_back(row_fixed(ACT_TICK, 3'd3, 8'h11, 1'b0, 1,
                                    t_wr'{3'd0, 8'hFF, 1'b1, 1'b1, 1'b1}));
        // count above the cell total, short dwell, spin every tick, all-ones seed
        dir_tab.push_back(row_cfg(CFG_COUNT, 32'd15));
        dir_tab.push_back(row_cfg(CFG_DWELL, 32'd3));
        dir_tab.push_back(row_cfg(CFG_SPIN, 32'd1));
        dir_tab.push_back(row_cfg(CFG_SEED, 32'hFFFF_FFFF));
        dir_tab.push_back(row_item(ACT_START, 3'd0, 8'h00, 1'b0));
        for (int i = 0; i < 4; i++) begin
            dir_tab.push_back(row_item(ACT_TICK, 3'd0, 8'h00, 1'b0));
        end
        // load while the animation runs, then move the cursor on
        dir_tab.push_back(row_item(ACT_LOAD, 3'd2, 8'h41, 1'b1));
        for (int i = 0; i < 3; i++) begin
            dir_tab.push_back(row_item(ACT_TICK, 3'd0, 8'h00, 1'b0));
        end
        // count lowered below the cursor: the next reveal ends the run
        dir_tab.push_back(row_cfg(CFG_COUNT, 32'd1));
        for (int i = 0; i < 3; i++) begin
            dir_tab.push_back(row_item(ACT_TICK, 3'd0, 8'h00, 1'b0));
        end
        // zero seed gets bit zero forced, restart while running, maximum dwell
        dir_tab.push_back(row_cfg(CFG_SEED, 32'd0));
        dir_tab.push_back(row_cfg(CFG_DWELL, 32'd65535));
        dir_tab.push_back(row_cfg(CFG_SPIN, 32'd2));
        dir_tab.push_back(row_cfg(CFG_COUNT, 32'd8));
        dir_tab.push_back(row_item(ACT_START, 3'd0, 8'h00, 1'b0));
        dir_tab.push_back(row_item(ACT_START, 3'd0, 8'h00, 1'b0));
        dir_tab.push_back(row_item(ACT_TICK, 3'd0, 8'h00, 1'b0));

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                cfg_write(dir_tab[i].cfg_reg, dir_tab[i].cfg_val);
            end else begin
                send(dir_tab[i].act, dir_tab[i].idx, dir_tab[i].ch, dir_tab[i].dot,
                     dir_tab[i].fixed, dir_tab[i].n_fixed, dir_tab[i].wr_fixed);
            end
        end

        // random phases: each one a new setting, some loads, a start and mostly ticks
        first_phase = 1'b1;
        while (rand_items < RAND_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            if (first_phase || $urandom_range(0, 1)) begin
                cfg_write(CFG_DWELL, ($urandom_range(0, 9) == 0) ?
                          $urandom_range(200, 65535) : $urandom_range(0, 6));
            end
            if (first_phase || $urandom_range(0, 1)) begin
                cfg_write(CFG_SPIN, ($urandom_range(0, 9) == 0) ?
                          $urandom_range(200, 65535) : $urandom_range(0, 4));
            end
            if (first_phase || $urandom_range(0, 1)) begin
                r = $urandom_range(0, 9);
                cfg_write(CFG_COUNT, (r == 0) ? 0 :
                          (r == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8));
            end
            if (first_phase || $urandom_range(0, 1)) begin
                cfg_write(CFG_SEED, $urandom);
            end
            first_phase = 1'b0;
            repeat ($urandom_range(0, 4)) send_rand(ACT_LOAD);
            send_rand(ACT_START);
            body_len = $urandom_range(12, 40);
            for (int j = 0; j < body_len; j++) begin
                r = $urandom_range(0, 31);
                if (r == 0) begin
                    send_rand(ACT_NONE);
                end else if (r <= 2) begin
                    send_rand(ACT_LOAD);
                end else if (r == 3) begin
                    send_rand(ACT_START);
                end else if (r == 4) begin
                    // count changed while the animation is under way
                    cfg_write(CFG_COUNT, $urandom_range(0, 15));
                end else begin
                    send_rand(ACT_TICK);
                end
            end
        end

        // equal limits: dwell and spin fall due on the same tick, dwell wins
        calm = 1'b1;
        cfg_write(CFG_DWELL, 32'd2);
        cfg_write(CFG_SPIN, 32'd2);
        cfg_write(CFG_COUNT, 32'd2);
        cfg_write(CFG_SEED, $urandom);
        send_rand(ACT_START);
        repeat (6) send_rand(ACT_TICK);
        calm = 1'b0;

        // drain and let the pipeline run empty
        s_axis_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(negedge i_clk);
        repeat (TAIL) @(negedge i_clk);

        $display("run covered %0d input transactions, %0d cell writes checked",
                 items_taken, outs_taken);
        $display("with %0d register writes across directed and random phases, %0d errors",
                 cfg_taken, errs);
        if (errs == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
